// ===== rtl/hkv_pkg.sv =====
// ----------------------------------------------------------------------------
// hkv_pkg
// Shared sizes, codes and types of the hashed key-value table.
// ----------------------------------------------------------------------------
package hkv_pkg;

  localparam int BUCKETS = 64;
  localparam int WAYS    = 4;
  localparam int NSLOTS  = BUCKETS * WAYS;

  localparam int KEY_W  = 31;
  localparam int VAL_W  = 32;
  localparam int OP_W   = 2;
  localparam int STAT_W = 2;

  localparam int BKT_W  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int SLOT_W = (NSLOTS > 1) ? $clog2(NSLOTS) : 1;

  // stream widths, padded to whole bytes
  localparam int IN_DATA_W  = ((KEY_W + VAL_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((VAL_W + 7) / 8) * 8;
  localparam int IN_USER_W  = OP_W;
  localparam int OUT_USER_W = STAT_W;

  // request opcodes
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
  localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

  // result status codes
  localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NOTFOUND = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL     = 2'd2;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_READ,
    SEQ_CHECK,
    SEQ_RESP
  } seq_state_t;

  // sequencer -> slot store
  typedef struct packed {
    logic              rd_en;
    logic              wr_en;
    logic              set_valid;
    logic              clr_valid;
    logic [SLOT_W-1:0] addr;
    logic [KEY_W-1:0]  key;
    logic [VAL_W-1:0]  value;
  } store_req_t;

  // slot store -> sequencer, registered read
  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } store_rsp_t;

  function automatic logic [SLOT_W-1:0] slot_addr(input logic [BKT_W-1:0] bkt,
                                                   input logic [WAY_W-1:0] way);
    logic [SLOT_W-1:0] base;
    base = SLOT_W'(bkt) * SLOT_W'(WAYS);
    return base + SLOT_W'(way);
  endfunction

endpackage

// ===== rtl/hkv_slot_store.sv =====
// ----------------------------------------------------------------------------
// hkv_slot_store
// Slot memory (key and value) with per-slot valid flops cleared at reset.
// ----------------------------------------------------------------------------
module hkv_slot_store (
  input  logic                clk,
  input  logic                rst_n,
  input  hkv_pkg::store_req_t req,
  output hkv_pkg::store_rsp_t rsp
);
  import hkv_pkg::*;

  logic [KEY_W+VAL_W-1:0] mem_r [NSLOTS];
  logic [KEY_W+VAL_W-1:0] rd_data_r;
  logic [NSLOTS-1:0]      valid_r;
  logic                   rd_valid_r;

  // key/value array, registered read
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem_r[req.addr] <= {req.key, req.value};
    end
    if (req.rd_en) begin
      rd_data_r <= mem_r[req.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (req.set_valid) begin
        valid_r[req.addr] <= 1'b1;
      end else if (req.clr_valid) begin
        valid_r[req.addr] <= 1'b0;
      end
      if (req.rd_en) begin
        rd_valid_r <= valid_r[req.addr];
      end
    end
  end

  assign rsp.valid = rd_valid_r;
  assign rsp.key   = rd_data_r[KEY_W+VAL_W-1:VAL_W];
  assign rsp.value = rd_data_r[VAL_W-1:0];

endmodule

// ===== rtl/hashed_key_value_table_top.sv =====
// ----------------------------------------------------------------------------
// hashed_key_value_table_top
// Hash table with bounded chains: BUCKETS rows of WAYS slots, key mod BUCKETS.
// ----------------------------------------------------------------------------
//
//  channel | dir | tdata                            | tuser
//  --------+-----+----------------------------------+----------------
//  in_     | in  | [30:0] key_in, [62:31] value_in  | [1:0] opcode
//  out_    | out | [31:0] value_out                 | [1:0] status
//
// Steps: a request walks its bucket one way at a time through a single
//   key comparator: per way a READ state (memory read), then a CHECK state
//   (compare), plus the IDLE accept and the RESP result. The worst case visits
//   all WAYS ways; any hit, insert included, stops at the matching way.
// The single-port slot memory and the shared comparator force that walk.
// Reset: valid flops of all slots clear at once; no clearing pass.
// Stalls: the result sits in an output register; a new request is taken
//   while it waits, and the next result holds until out_tready frees it.
// ----------------------------------------------------------------------------
module hashed_key_value_table_top (
  input  logic                              clk,
  input  logic                              rst_n,
  // request channel
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [hkv_pkg::IN_DATA_W-1:0]     in_tdata,   // key_in, value_in
  input  logic [hkv_pkg::IN_USER_W-1:0]     in_tuser,   // opcode
  // result channel
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [hkv_pkg::OUT_DATA_W-1:0]    out_tdata,  // value_out
  output logic [hkv_pkg::OUT_USER_W-1:0]    out_tuser   // status
);
  import hkv_pkg::*;

  seq_state_t         state_r, state_nxt;
  logic [OP_W-1:0]    op_r, op_nxt;
  logic [KEY_W-1:0]   key_r, key_nxt;
  logic [VAL_W-1:0]   val_r, val_nxt;
  logic [BKT_W-1:0]   bkt_r, bkt_nxt;
  logic [WAY_W-1:0]   way_r, way_nxt;
  logic               free_found_r, free_found_nxt;
  logic [WAY_W-1:0]   free_way_r, free_way_nxt;
  logic [STAT_W-1:0]  res_stat_r, res_stat_nxt;
  logic [VAL_W-1:0]   res_val_r, res_val_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0]  out_stat_r, out_stat_nxt;
  logic [VAL_W-1:0]   out_val_r, out_val_nxt;

  store_req_t         sreq;
  store_rsp_t         srsp;

  logic               in_fire;
  logic               hit;
  logic               last_way;
  logic               free_now;
  logic [WAY_W-1:0]   free_sel;
  logic [KEY_W-1:0]   in_key;

  assign in_key   = in_tdata[KEY_W-1:0];
  assign in_fire  = in_tvalid && in_tready;
  assign in_tready = (state_r == SEQ_IDLE);

  // shared comparator: one way of the bucket per check cycle
  assign hit      = srsp.valid && (srsp.key == key_r);
  assign last_way = (way_r == WAY_W'(WAYS - 1));
  assign free_now = free_found_r || !srsp.valid;
  assign free_sel = free_found_r ? free_way_r : way_r;

  hkv_slot_store u_store (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (sreq),
    .rsp  (srsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= SEQ_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    key_r        <= key_nxt;
    val_r        <= val_nxt;
    bkt_r        <= bkt_nxt;
    way_r        <= way_nxt;
    free_found_r <= free_found_nxt;
    free_way_r   <= free_way_nxt;
    res_stat_r   <= res_stat_nxt;
    res_val_r    <= res_val_nxt;
    out_stat_r   <= out_stat_nxt;
    out_val_r    <= out_val_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    key_nxt        = key_r;
    val_nxt        = val_r;
    bkt_nxt        = bkt_r;
    way_nxt        = way_r;
    free_found_nxt = free_found_r;
    free_way_nxt   = free_way_r;
    res_stat_nxt   = res_stat_r;
    res_val_nxt    = res_val_r;
    out_valid_nxt  = out_valid_r;
    out_stat_nxt   = out_stat_r;
    out_val_nxt    = out_val_r;

    sreq           = '0;
    sreq.addr      = slot_addr(bkt_r, way_r);
    sreq.key       = key_r;
    sreq.value     = val_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      SEQ_IDLE: begin
        if (in_fire) begin
          op_nxt         = in_tuser[OP_W-1:0];
          key_nxt        = in_key;
          val_nxt        = in_tdata[KEY_W+VAL_W-1:KEY_W];
          bkt_nxt        = BKT_W'(in_key % BUCKETS);
          way_nxt        = '0;
          free_found_nxt = 1'b0;
          free_way_nxt   = '0;
          state_nxt      = SEQ_READ;
        end
      end

      SEQ_READ: begin
        sreq.rd_en = 1'b1;
        state_nxt  = SEQ_CHECK;
      end

      SEQ_CHECK: begin
        res_stat_nxt = STAT_NOTFOUND;
        res_val_nxt  = '0;
        if (hit) begin
          state_nxt = SEQ_RESP;
          case (op_r)
            OP_LOOKUP: begin
              res_stat_nxt = STAT_OK;
              res_val_nxt  = srsp.value;
            end
            OP_INSERT: begin
              sreq.wr_en     = 1'b1;
              sreq.set_valid = 1'b1;
              res_stat_nxt   = STAT_OK;
            end
            OP_REMOVE: begin
              sreq.clr_valid = 1'b1;
              res_stat_nxt   = STAT_OK;
              res_val_nxt    = srsp.value;
            end
            default: begin
              res_stat_nxt = STAT_NOTFOUND;
            end
          endcase
        end else if (last_way) begin
          state_nxt = SEQ_RESP;
          if (op_r == OP_INSERT) begin
            if (free_now) begin
              // new key goes into the lowest free way seen
              sreq.addr      = slot_addr(bkt_r, free_sel);
              sreq.wr_en     = 1'b1;
              sreq.set_valid = 1'b1;
              res_stat_nxt   = STAT_OK;
            end else begin
              res_stat_nxt = STAT_FULL;
            end
          end
        end else begin
          if (!free_found_r && !srsp.valid) begin
            free_found_nxt = 1'b1;
            free_way_nxt   = way_r;
          end
          way_nxt   = way_r + WAY_W'(1);
          state_nxt = SEQ_READ;
        end
      end

      SEQ_RESP: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_stat_nxt  = res_stat_r;
          out_val_nxt   = res_val_r;
          state_nxt     = SEQ_IDLE;
        end
      end

      default: begin
        state_nxt = SEQ_IDLE;
      end
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_stat_r;
  assign out_tdata  = OUT_DATA_W'(out_val_r);

  // a taken request always starts with a memory read
  a_accept_reads: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == SEQ_READ))
    else $error("accepted request did not start a bucket read");

  // the slot store never sees a read and a write together
  a_no_rd_wr: assert property (@(posedge clk) disable iff (!rst_n)
    sreq.rd_en |-> !(sreq.wr_en || sreq.clr_valid))
    else $error("slot read and write in the same cycle");

  // slot updates happen only while checking a way
  a_wr_in_check: assert property (@(posedge clk) disable iff (!rst_n)
    (sreq.wr_en || sreq.clr_valid) |-> (state_r == SEQ_CHECK))
    else $error("slot update outside the check step");

  // misses and full buckets carry a zero value
  a_zero_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_stat_r == STAT_FULL || out_stat_r == STAT_NOTFOUND))
      |-> (out_val_r == '0))
    else $error("nonzero value with a failing status");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for hashed_key_value_table_top. A directed table walks
// reset state, key and value extremes, full buckets, updates, removes and the
// unused opcode. A random phase then hammers a few hot buckets with colliding
// keys. Every accepted request runs through a shadow copy of the slot store;
// each result is compared with the oldest pending prediction.
// ----------------------------------------------------------------------------
module tb;
  import hkv_pkg::*;

  // opcode 3 is not decoded by the block; it must answer "not found"
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam logic [KEY_W-1:0] KEY_MAX  = {KEY_W{1'b1}};

  localparam int N_DIR           = 24;
  localparam int N_RANDOM        = 550;
  localparam int CHUNK           = 50;
  localparam int BURST_LEN       = 30;
  localparam int HOLD_OFF_CYCLES = 200;
  localparam int N_HOT_BKT       = 6;
  localparam int N_HOT_TAG       = 8;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [VAL_W-1:0]  value;
  } table_result_t;

  // one directed request; typed rows carry a hand-written result
  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [KEY_W-1:0]  key;
    logic [VAL_W-1:0]  value;
    logic              typed;
    logic [STAT_W-1:0] exp_status;
    logic [VAL_W-1:0]  exp_value;
  } request_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;   // [30:0] key_in, [62:31] value_in
  logic [IN_USER_W-1:0]  in_tuser;   // [1:0] opcode
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;  // [31:0] value_out
  logic [OUT_USER_W-1:0] out_tuser;  // [1:0] status

  hashed_key_value_table_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // shadow of the slot store, slot = bucket * WAYS + way
  bit                 shadow_valid [NSLOTS];
  logic [KEY_W-1:0]   shadow_key   [NSLOTS];
  logic [VAL_W-1:0]   shadow_value [NSLOTS];

  table_result_t      pending_results [$];
  int                 err_count;

  // traffic shaping shared between the request and result sides
  bit                 sender_steady;
  bit                 hold_off_req;
  int                 hot_bkt [N_HOT_BKT];
  longint             hot_tag [N_HOT_TAG];

  request_row_t dir_rows [N_DIR] = '{
    // empty table after reset
    '{OP_LOOKUP, 31'h0000_0000, 32'h0000_0000, 1'b1, STAT_NOTFOUND, 32'h0},
    '{OP_REMOVE, KEY_MAX,       32'h0000_0000, 1'b1, STAT_NOTFOUND, 32'h0},
    '{OP_UNUSED, 31'h0000_0005, 32'hFFFF_FFFF, 1'b1, STAT_NOTFOUND, 32'h0},
    // largest key with largest value, bucket 63
    '{OP_INSERT, KEY_MAX,       32'hFFFF_FFFF, 1'b1, STAT_OK,       32'h0},
    '{OP_LOOKUP, KEY_MAX,       32'h0000_0000, 1'b1, STAT_OK,       32'hFFFF_FFFF},
    // fill bucket 0, then overflow it
    '{OP_INSERT, 31'h0000_0000, 32'h0000_0000, 1'b1, STAT_OK,       32'h0},
    '{OP_INSERT, 31'h0000_0040, 32'h1234_5678, 1'b0, STAT_OK,       32'h0},
    '{OP_INSERT, 31'h0000_0080, 32'h0000_0001, 1'b0, STAT_OK,       32'h0},
    '{OP_INSERT, 31'h0000_00C0, 32'h8000_0000, 1'b0, STAT_OK,       32'h0},
    '{OP_INSERT, 31'h0000_0100, 32'h0000_000C, 1'b1, STAT_FULL,     32'h0},
    // update in a full bucket, then free a middle way and refill it
    '{OP_INSERT, 31'h0000_0040, 32'hDEAD_BEEF, 1'b0, STAT_OK,       32'h0},
    '{OP_LOOKUP, 31'h0000_0040, 32'h0000_0000, 1'b0, STAT_OK,       32'h0},
    '{OP_REMOVE, 31'h0000_0040, 32'h0000_0000, 1'b0, STAT_OK,       32'h0},
    '{OP_LOOKUP, 31'h0000_0040, 32'h0000_0000, 1'b0, STAT_OK,       32'h0},
    '{OP_INSERT, 31'h0000_0100, 32'h5555_5555, 1'b0, STAT_OK,       32'h0},
    '{OP_LOOKUP, 31'h0000_0100, 32'h0000_0000, 1'b0, STAT_OK,       32'h0},
    '{OP_REMOVE, 31'h0000_0000, 32'h0000_0000, 1'b0, STAT_OK,       32'h0},
    // unused opcode leaves the entry alone
    '{OP_UNUSED, KEY_MAX,       32'h0000_0000, 1'b1, STAT_NOTFOUND, 32'h0},
    '{OP_LOOKUP, KEY_MAX,       32'h0000_0000, 1'b1, STAT_OK,       32'hFFFF_FFFF},
    '{OP_REMOVE, KEY_MAX,       32'h0000_0000, 1'b1, STAT_OK,       32'hFFFF_FFFF},
    '{OP_REMOVE, KEY_MAX,       32'h0000_0000, 1'b1, STAT_NOTFOUND, 32'h0},
    // alternating bit patterns
    '{OP_INSERT, 31'h2AAA_AAAA, 32'hAAAA_AAAA, 1'b0, STAT_OK,       32'h0},
    '{OP_LOOKUP, 31'h5555_5555, 32'h0000_0000, 1'b1, STAT_NOTFOUND, 32'h0},
    '{OP_LOOKUP, 31'h2AAA_AAAA, 32'h0000_0000, 1'b0, STAT_OK,       32'h0}
  };

  // --------------------------------------------------------------------------
  // Shadow table: applies one request, returns the result it must produce.
  // A key matches only in a valid way; inserts take the lowest free way.
  // --------------------------------------------------------------------------
  function automatic table_result_t apply_request(input logic [OP_W-1:0]  op,
                                                  input logic [KEY_W-1:0] key,
                                                  input logic [VAL_W-1:0] val);
    table_result_t res;
    int base;
    int hit;
    int spare;
    int w;
    res.status = STAT_NOTFOUND;
    res.value  = '0;
    base  = int'(key % BUCKETS) * WAYS;
    hit   = -1;
    spare = -1;
    for (w = 0; w < WAYS; w++) begin
      if (hit < 0 && shadow_valid[base + w] && shadow_key[base + w] == key) hit = w;
      if (spare < 0 && !shadow_valid[base + w]) spare = w;
    end
    case (op)
      OP_LOOKUP: begin
        if (hit >= 0) begin
          res.status = STAT_OK;
          res.value  = shadow_value[base + hit];
        end
      end
      OP_INSERT: begin
        if (hit >= 0) begin
          shadow_value[base + hit] = val;
          res.status = STAT_OK;
        end else if (spare >= 0) begin
          shadow_valid[base + spare] = 1'b1;
          shadow_key[base + spare]   = key;
          shadow_value[base + spare] = val;
          res.status = STAT_OK;
        end else begin
          res.status = STAT_FULL;
        end
      end
      OP_REMOVE: begin
        if (hit >= 0) begin
          res.status = STAT_OK;
          res.value  = shadow_value[base + hit];
          shadow_valid[base + hit] = 1'b0;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // idle length: mostly short, now and then long
  function automatic int gap_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 94) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [OP_W-1:0] pick_op();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return OP_INSERT;
    if (r < 70) return OP_LOOKUP;
    if (r < 95) return OP_REMOVE;
    return OP_UNUSED;
  endfunction

  // Mostly keys that collide in a few hot buckets, so rows fill, overflow
  // and get hits; the rest are full-range keys and the two extremes.
  function automatic logic [KEY_W-1:0] pick_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return KEY_W'($urandom());
    if (r < 12) return KEY_MAX;
    if (r < 14) return '0;
    return KEY_W'(hot_tag[$urandom_range(0, N_HOT_TAG - 1)] * BUCKETS
                  + hot_bkt[$urandom_range(0, N_HOT_BKT - 1)]);
  endfunction

  // --------------------------------------------------------------------------
  // Offer one request and hold it until accepted; the prediction is queued
  // at the accepting edge. Valid stays high between back-to-back requests.
  // --------------------------------------------------------------------------
  task automatic send_request(input logic [OP_W-1:0]   op,
                              input logic [KEY_W-1:0]  key,
                              input logic [VAL_W-1:0]  val,
                              input logic              typed,
                              input table_result_t     typed_res);
    logic [IN_DATA_W-1:0] word;
    table_result_t        predicted;
    int                   gap;
    gap = (sender_steady || $urandom_range(0, 1) == 0) ? 0 : gap_cycles();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    word = '0;
    word[KEY_W-1:0]     = key;
    word[KEY_W +: VAL_W] = val;
    in_tvalid <= 1'b1;
    in_tdata  <= word;
    in_tuser  <= op;
    do @(posedge clk); while (!in_tready);
    predicted = apply_request(op, key, val);
    pending_results.push_back(typed ? typed_res : predicted);
  endtask

  // --------------------------------------------------------------------------
  // Clock, and a hard limit far beyond the slowest legal run
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("simulation failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Result side readiness: ready bursts, random stalls, and a long hold-off
  // on demand so that the output register fills and the input backs up.
  // --------------------------------------------------------------------------
  initial begin
    int r;
    out_tready <= 1'b0;
    forever begin
      if (hold_off_req) begin
        out_tready <= 1'b0;
        hold_off_req = 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 10) begin
          out_tready <= 1'b1;
          repeat ($urandom_range(50, 150)) @(posedge clk);
        end else if (r < 60) begin
          out_tready <= 1'b1;
          repeat ($urandom_range(1, 4)) @(posedge clk);
        end else begin
          out_tready <= 1'b0;
          repeat (gap_cycles()) @(posedge clk);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result checker: every accepted result against the oldest prediction
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    table_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: status %0d value_out %h", out_tuser, out_tdata);
        err_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_tuser !== want.status) begin
          $error("status mismatch: expected %0d, actual %0d", want.status, out_tuser);
          err_count++;
        end
        if (out_tdata[VAL_W-1:0] !== want.value) begin
          $error("value_out mismatch: expected %h, actual %h",
                 want.value, out_tdata[VAL_W-1:0]);
          err_count++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus: reset, directed table, then random requests in chunks with
  // varying idle style, one receiver hold-off burst and one full drain.
  // --------------------------------------------------------------------------
  initial begin
    int            i;
    int            chunk;
    table_result_t typed_res;
    err_count     = 0;
    sender_steady = 1'b0;
    hold_off_req  = 1'b0;
    for (i = 0; i < NSLOTS; i++) shadow_valid[i] = 1'b0;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= OP_LOOKUP;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (i = 0; i < N_DIR; i++) begin
      typed_res.status = dir_rows[i].exp_status;
      typed_res.value  = dir_rows[i].exp_value;
      send_request(dir_rows[i].op, dir_rows[i].key, dir_rows[i].value,
                   dir_rows[i].typed, typed_res);
    end

    // sender pause: let every outstanding request come back
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);

    for (i = 0; i < N_HOT_BKT; i++) hot_bkt[i] = $urandom_range(0, BUCKETS - 1);
    hot_bkt[0] = 0;
    hot_bkt[1] = BUCKETS - 1;
    for (i = 0; i < N_HOT_TAG; i++) hot_tag[i] = $urandom_range(0, KEY_MAX / BUCKETS);
    hot_tag[0] = 0;
    hot_tag[1] = KEY_MAX / BUCKETS;

    typed_res = '0;
    for (chunk = 0; chunk < N_RANDOM / CHUNK; chunk++) begin
      sender_steady = ($urandom_range(0, 3) == 0);
      if (chunk == 3) begin
        // receiver stalls long while requests keep coming back to back
        in_tvalid <= 1'b0;
        hold_off_req = 1'b1;
        while (hold_off_req) @(posedge clk);
        sender_steady = 1'b1;
        for (i = 0; i < BURST_LEN; i++)
          send_request(pick_op(), pick_key(), $urandom(), 1'b0, typed_res);
        sender_steady = 1'b0;
        for (i = BURST_LEN; i < CHUNK; i++)
          send_request(pick_op(), pick_key(), $urandom(), 1'b0, typed_res);
      end else begin
        if (chunk == 6) begin
          in_tvalid <= 1'b0;
          while (pending_results.size() != 0) @(posedge clk);
        end
        for (i = 0; i < CHUNK; i++)
          send_request(pick_op(), pick_key(), $urandom(), 1'b0, typed_res);
      end
    end
    in_tvalid <= 1'b0;

    // drain, then leave room for any stray late result
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4 * WAYS + 4) @(posedge clk);

    if (err_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
